// ===== rtl/aa_quarter_circle_coverage_top_macros.svh =====
// Assertion helpers for the module that checks itself.
// Both expect a clock named clk and an active-low asynchronous reset named arst_n in scope.
`ifndef AA_QUARTER_CIRCLE_COVERAGE_TOP_MACROS_SVH
`define AA_QUARTER_CIRCLE_COVERAGE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AQC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AQC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/aqc_pkg.sv =====
package aqc_pkg;

	localparam int COORD_W  = 11;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int DELTA_W  = DIFF_W + 1;
	localparam int SQ_W     = 24;
	// Sum of two squares needs 25 bits; one more keeps the radicand an even number of bits.
	localparam int SUM_W    = 26;
	localparam int RADIUS_W = 8;
	localparam int MASK_W   = 8;

	localparam logic [MASK_W-1:0] MASK_FULL = 8'hFF;
	localparam logic [MASK_W-1:0] MASK_NONE = 8'h00;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_CENTER_X      = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_Y      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS        = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_QUADRANT_TOP  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_QUADRANT_LEFT = 3'd4;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic [RADIUS_W-1:0]       radius;
		logic                      quadrant_top;
		logic                      quadrant_left;
	} cfg_t;

endpackage

// ===== rtl/aqc_cfg.sv =====
module aqc_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aqc_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [aqc_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [aqc_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready,
	output aqc_pkg::cfg_t                     cfg
);
	import aqc_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;

	// Registers sit on word boundaries; the two low address bits are not decoded.
	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x      <= '0;
			cfg_q.center_y      <= '0;
			cfg_q.radius        <= RADIUS_W'(1);
			cfg_q.quadrant_top  <= 1'b0;
			cfg_q.quadrant_left <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				REG_CENTER_X:      cfg_q.center_x      <= pwdata[COORD_W-1:0];
				REG_CENTER_Y:      cfg_q.center_y      <= pwdata[COORD_W-1:0];
				REG_RADIUS:        cfg_q.radius        <= pwdata[RADIUS_W-1:0];
				REG_QUADRANT_TOP:  cfg_q.quadrant_top  <= pwdata[0];
				REG_QUADRANT_LEFT: cfg_q.quadrant_left <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_CENTER_X: begin
				prdata = {{(APB_DATA_W-COORD_W){cfg_q.center_x[COORD_W-1]}}, cfg_q.center_x};
			end
			REG_CENTER_Y: begin
				prdata = {{(APB_DATA_W-COORD_W){cfg_q.center_y[COORD_W-1]}}, cfg_q.center_y};
			end
			REG_RADIUS:        prdata = {{(APB_DATA_W-RADIUS_W){1'b0}}, cfg_q.radius};
			REG_QUADRANT_TOP:  prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.quadrant_top};
			REG_QUADRANT_LEFT: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_q.quadrant_left};
			default:           prdata = '0;
		endcase
	end

endmodule

// ===== rtl/aqc_front.sv =====
module aqc_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [aqc_pkg::COORD_W-1:0]  pixel_x,
	input  logic signed [aqc_pkg::COORD_W-1:0]  pixel_y,
	input  aqc_pkg::cfg_t                       cfg,
	output logic                                out_valid,
	output logic                                out_wrong,
	output logic [aqc_pkg::SUM_W-1:0]           out_sum
);
	import aqc_pkg::*;

	logic signed [DIFF_W-1:0]    diff_x, diff_y;
	logic signed [2*DELTA_W-1:0] prod_x, prod_y;

	logic                      valid_s1, wrong_s1;
	logic signed [DELTA_W-1:0] dx_s1, dy_s1;
	logic                      valid_s2, wrong_s2;
	logic [SQ_W-1:0]           dx2_s2, dy2_s2;
	logic                      valid_s3, wrong_s3;
	logic [SUM_W-1:0]          sum_s3;

	assign diff_x = {pixel_x[COORD_W-1], pixel_x} - {cfg.center_x[COORD_W-1], cfg.center_x};
	assign diff_y = {pixel_y[COORD_W-1], pixel_y} - {cfg.center_y[COORD_W-1], cfg.center_y};

	assign prod_x = dx_s1 * dx_s1;
	assign prod_y = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// The doubled offset plus one is odd, so its sign is the sign of the difference.
			dx_s1    <= {diff_x, 1'b1};
			dy_s1    <= {diff_y, 1'b1};
			wrong_s1 <= (cfg.quadrant_left ^ diff_x[DIFF_W-1])
				|| (cfg.quadrant_top ^ diff_y[DIFF_W-1]);
			dx2_s2   <= prod_x[SQ_W-1:0];
			dy2_s2   <= prod_y[SQ_W-1:0];
			wrong_s2 <= wrong_s1;
			sum_s3   <= SUM_W'(dx2_s2) + SUM_W'(dy2_s2);
			wrong_s3 <= wrong_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_wrong = wrong_s3;
	assign out_sum   = sum_s3;

endmodule

// ===== rtl/aqc_isqrt.sv =====
module aqc_isqrt #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic                                          in_valid,
	input  logic                                          in_wrong,
	input  logic [aqc_pkg::SUM_W-1:0]                     in_sum,
	output logic                                          out_valid,
	output logic                                          out_wrong,
	output logic [(aqc_pkg::SUM_W+2*FRAC_BITS)/2-1:0]     out_root
);
	import aqc_pkg::*;

	localparam int RW   = SUM_W + 2*FRAC_BITS;
	localparam int QW   = RW / 2;
	localparam int REMW = QW + 2;

	// One result bit per stage: restoring digit-by-digit square root.
	logic [RW-1:0]   rad_s   [QW];
	logic [QW-1:0]   root_s  [QW];
	logic [REMW-1:0] rem_s   [QW];
	logic            valid_s [QW];
	logic            wrong_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_step
		logic [RW-1:0]   rad_in;
		logic [QW-1:0]   root_in;
		logic [REMW-1:0] rem_in;
		logic            valid_in, wrong_in;
		logic [REMW-1:0] trial, test;
		logic            take;

		if (i == 0) begin : g_first
			assign rad_in   = {in_sum, {(2*FRAC_BITS){1'b0}}};
			assign root_in  = '0;
			assign rem_in   = '0;
			assign valid_in = in_valid;
			assign wrong_in = in_wrong;
		end else begin : g_next
			assign rad_in   = rad_s[i-1];
			assign root_in  = root_s[i-1];
			assign rem_in   = rem_s[i-1];
			assign valid_in = valid_s[i-1];
			assign wrong_in = wrong_s[i-1];
		end

		assign trial = {rem_in[REMW-3:0], rad_in[RW-1:RW-2]};
		assign test  = {root_in, 2'b01};
		assign take  = trial >= test;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i]   <= {rad_in[RW-3:0], 2'b00};
				root_s[i]  <= {root_in[QW-2:0], take};
				rem_s[i]   <= take ? (trial - test) : trial;
				wrong_s[i] <= wrong_in;
			end
		end
	end

	assign out_valid = valid_s[QW-1];
	assign out_wrong = wrong_s[QW-1];
	assign out_root  = root_s[QW-1];

endmodule

// ===== rtl/aqc_mask.sv =====
module aqc_mask #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic                                          in_valid,
	input  logic                                          in_wrong,
	input  logic [(aqc_pkg::SUM_W+2*FRAC_BITS)/2-1:0]     in_root,
	input  logic [aqc_pkg::RADIUS_W-1:0]                  radius,
	output logic                                          out_valid,
	output logic [aqc_pkg::MASK_W-1:0]                    out_mask
);
	import aqc_pkg::*;

	localparam int QW = (SUM_W + 2*FRAC_BITS) / 2;
	localparam int CW = QW + 2;
	localparam int XW = FRAC_BITS + 1;
	localparam int PW = XW + MASK_W;
	localparam logic signed [CW-1:0] ONE2 = CW'(2) << FRAC_BITS;

	logic [CW-1:0]        edge_lim;
	logic signed [CW-1:0] span;
	logic [XW-1:0]        frac;
	logic [PW-1:0]        scaled;
	logic [MASK_W-1:0]    mask_nx;

	logic                 valid_s1, wrong_s1;
	logic signed [CW-1:0] c2_s1;
	logic                 valid_s2;
	logic [MASK_W-1:0]    mask_s2;

	// Twice the outer edge, r + 0.5, in the same fixed point as the doubled distance.
	assign edge_lim = {{(CW-RADIUS_W-1-FRAC_BITS){1'b0}}, radius, 1'b1, {FRAC_BITS{1'b0}}};

	assign span   = ONE2 - c2_s1;
	assign frac   = span[XW-1:0];
	assign scaled = {frac, {MASK_W{1'b0}}} - PW'(frac);

	always_comb begin
		priority if (wrong_s1 || c2_s1 <= 0) begin
			mask_nx = MASK_FULL;
		end else if (c2_s1 >= ONE2) begin
			mask_nx = MASK_NONE;
		end else begin
			mask_nx = scaled[PW-1:XW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c2_s1    <= $signed(edge_lim) - $signed(CW'(in_root));
			wrong_s1 <= in_wrong;
			mask_s2  <= mask_nx;
		end
	end

	assign out_valid = valid_s2;
	assign out_mask  = mask_s2;

endmodule

// ===== rtl/aa_quarter_circle_coverage_top.sv =====
// Anti-aliased quarter circle coverage mask. Each word on the pixel channel is one pixel
// coordinate; each word on the mask channel is its 8-bit blend mask, 0 for full colour and 255
// for full background, in the same order. Pixels on the far side of the configured centre in x
// or y get 255; others are graded by the distance of the pixel centre from the circle centre,
// with a one pixel wide soft edge centred on the radius. The block takes one pixel every
// clock while the skid stage is empty and has no dependence between pixels, so a raster
// walker can stream a whole corner box without gaps. An accepted pixel passes through the
// front stages, which form the offsets, their squares and their sum, then the square-root
// chain, one result bit per stage and longer for a larger FRAC_BITS, then the mask stages,
// which form the coverage and scale it, and last the output register. The pipeline moves
// only while the skid stage behind the output register is empty, so a stalled consumer holds
// every word in place and nothing is lost or repeated. Registers (centre x and y, radius,
// quadrant top, quadrant left) sit at byte addresses 0, 4, 8, 12 and 16 of the APB port and
// must only be written while no pixel is in flight. There is no clearing pass after reset.
`include "aa_quarter_circle_coverage_top_macros.svh"

module aa_quarter_circle_coverage_top #(
	parameter int FRAC_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [aqc_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [aqc_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [aqc_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  logic signed [aqc_pkg::COORD_W-1:0]  pixel_x,
	input  logic signed [aqc_pkg::COORD_W-1:0]  pixel_y,
	output logic                                mask_valid,
	input  logic                                mask_ready,
	output logic [aqc_pkg::MASK_W-1:0]          mask_value
);
	import aqc_pkg::*;

	localparam int QW = (SUM_W + 2*FRAC_BITS) / 2;

	cfg_t              cfg;
	logic              en;
	logic              front_valid, front_wrong;
	logic [SUM_W-1:0]  front_sum;
	logic              root_valid, root_wrong;
	logic [QW-1:0]     root;
	logic              res_valid;
	logic [MASK_W-1:0] res_mask;

	logic              out_valid_q;
	logic [MASK_W-1:0] out_mask_q;
	logic              skid_valid_q;
	logic [MASK_W-1:0] skid_mask_q;
	logic              pop, push;

	aqc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The whole pipeline advances together; it stops only when the skid stage holds a word.
	assign en          = !skid_valid_q;
	assign pixel_ready = en;

	aqc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pixel_valid),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.cfg       (cfg),
		.out_valid (front_valid),
		.out_wrong (front_wrong),
		.out_sum   (front_sum)
	);

	aqc_isqrt #(
		.FRAC_BITS (FRAC_BITS)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.in_wrong  (front_wrong),
		.in_sum    (front_sum),
		.out_valid (root_valid),
		.out_wrong (root_wrong),
		.out_root  (root)
	);

	aqc_mask #(
		.FRAC_BITS (FRAC_BITS)
	) u_mask (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (root_valid),
		.in_wrong  (root_wrong),
		.in_root   (root),
		.radius    (cfg.radius),
		.out_valid (res_valid),
		.out_mask  (res_mask)
	);

	// Output register with a skid stage behind it. A word leaving the pipeline goes to the
	// output register when that is free or being emptied, otherwise into the skid stage.
	assign pop  = out_valid_q && mask_ready;
	assign push = en && res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= out_valid_q && !mask_ready;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (skid_valid_q) begin
			if (pop) begin
				out_mask_q <= skid_mask_q;
			end
		end else if (push) begin
			if (out_valid_q && !mask_ready) begin
				skid_mask_q <= res_mask;
			end else begin
				out_mask_q <= res_mask;
			end
		end
	end

	assign mask_valid = out_valid_q;
	assign mask_value = out_mask_q;

	// The skid stage is only ever filled behind a waiting output word.
	`AQC_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full, output empty")
	// A word arriving at a stalled output must land in the skid stage.
	`AQC_ASSERT_NEXT(a_stall_to_skid, push && out_valid_q && !mask_ready, skid_valid_q, "word lost")
	// Draining the skid stage moves its word forward and frees the pipeline.
	`AQC_ASSERT_NEXT(a_skid_drain, skid_valid_q && pop, mask_valid && !skid_valid_q, "skid stuck")

endmodule
